// ===== design/lto_pkg.sv =====
// Shared types, widths and constants for the LoRa duration calculator.
package lto_pkg;

    typedef enum logic [1:0] {
        REQ_TOA = 2'd0,
        REQ_RX1 = 2'd1,
        REQ_RX2 = 2'd2,
        REQ_PRE = 2'd3
    } lto_req_t;

    localparam int LEN_W  = 8;
    localparam int SF_W   = 4;
    localparam int CR_W   = 3;
    localparam int PRE_W  = 16;
    localparam int BW_W   = 19;
    localparam int DUR_W  = 46;
    localparam int PSYM_W = 11;
    localparam int PREQ_W = 19;

    // quarter-symbol count, quarters << sf, numerator scaled to ns, divisor 4*bw
    localparam int Q_W   = 19;
    localparam int K_W   = 31;
    localparam int NS_W  = 30;
    localparam int NUM_W = 60;
    localparam int DEN_W = BW_W + 2;

    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = DUR_W / DIV_STEPS;

    // payload block count via reciprocal: y < 2^Y_W, divisor 4..12
    localparam int Y_W         = 10;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 16;
    localparam int BLK_W       = 8;
    localparam int NUMS_W      = 13;

    localparam logic [SF_W-1:0] SF_MIN     = 4'd6;
    localparam logic [SF_W-1:0] SF_MAX     = 4'd12;
    localparam logic [SF_W-1:0] SF_LONG_RX = 4'd11;
    localparam logic [CR_W-1:0] CR_MIN     = 3'd1;
    localparam logic [CR_W-1:0] CR_MAX     = 3'd4;
    localparam logic [BW_W-1:0] BW_MIN     = 19'd7800;

    localparam logic [NS_W-1:0] NS_PER_S   = 30'd1000000000;
    localparam logic [Q_W-1:0]  RX1_Q_LONG  = 19'd32;
    localparam logic [Q_W-1:0]  RX1_Q_SHORT = 19'd48;
    localparam logic [Q_W-1:0]  PRE_EXTRA_Q = 19'd17;
    localparam logic [K_W-1:0]  CAD_EXTRA_K = 31'd128;

    typedef struct packed {
        logic [PSYM_W-1:0] psym;
        logic [PREQ_W-1:0] preq;
    } lto_side_t;

    // ceil(2^16 / m), exact for y below 2^Y_W
    function automatic logic [RECIP_W-1:0] recip(input logic [SF_W-1:0] m);
        logic [RECIP_W-1:0] r;
        case (m)
            4'd4:    r = 15'd16384;
            4'd5:    r = 15'd13108;
            4'd6:    r = 15'd10923;
            4'd7:    r = 15'd9363;
            4'd8:    r = 15'd8192;
            4'd9:    r = 15'd7282;
            4'd10:   r = 15'd6554;
            4'd11:   r = 15'd5958;
            4'd12:   r = 15'd5462;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/lora_time_on_air.sv =====
// Top level of the LoRa duration calculator: front end, scaling and divider pipeline.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------------
//   request | req_valid | req_stall | req_type .. bandwidth_hz (one port per field)
//   result  | rsp_valid | rsp_stall | duration_ns, payload_symbol_count,
//           |           |           | preamble_quarter_symbols
//
// 3 decode/symbol stages, 2 scaling stages (shift, x1e9 multiply) and 23 divider stages
// of 2 quotient bits each; one item per cycle throughput while no result is stalled.
// The last divider stage is the output register. While a result sits stalled the
// whole pipeline holds and req_stall is raised.
// Reset clears the stage valid bits only; there is no stored state.
module lora_time_on_air (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    req_type,
    input  logic [lto_pkg::LEN_W-1:0]     payload_len,
    input  logic [lto_pkg::SF_W-1:0]      spreading_factor,
    input  logic [lto_pkg::CR_W-1:0]      coding_rate,
    input  logic [lto_pkg::PRE_W-1:0]     preamble_symbols,
    input  logic                          header_implicit,
    input  logic                          crc_on,
    input  logic                          low_rate_opt,
    input  logic [lto_pkg::BW_W-1:0]      bandwidth_hz,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [lto_pkg::DUR_W-1:0]     duration_ns,
    output logic [lto_pkg::PSYM_W-1:0]    payload_symbol_count,
    output logic [lto_pkg::PREQ_W-1:0]    preamble_quarter_symbols
);

    logic                          en;
    logic                          sym_valid;
    lto_pkg::lto_req_t             sym_req;
    logic [lto_pkg::SF_W-1:0]      sym_sf;
    logic [lto_pkg::BW_W-1:0]      sym_bw;
    logic [lto_pkg::Q_W-1:0]       sym_q;
    lto_pkg::lto_side_t            sym_side;
    logic                          scl_valid;
    logic [lto_pkg::NUM_W-1:0]     scl_num;
    logic [lto_pkg::DEN_W-1:0]     scl_den;
    lto_pkg::lto_side_t            scl_side;

    logic                          dv   [0:lto_pkg::DIV_STAGES];
    logic [lto_pkg::DEN_W-1:0]     drem [0:lto_pkg::DIV_STAGES];
    logic [lto_pkg::DUR_W-1:0]     dquo [0:lto_pkg::DIV_STAGES];
    logic [lto_pkg::DEN_W-1:0]     dden [0:lto_pkg::DIV_STAGES];
    lto_pkg::lto_side_t            dside[0:lto_pkg::DIV_STAGES];

    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = rsp_valid && rsp_stall;

    lto_symbols u_symbols (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .valid            (req_valid),
        .req_type         (req_type),
        .payload_len      (payload_len),
        .spreading_factor (spreading_factor),
        .coding_rate      (coding_rate),
        .preamble_symbols (preamble_symbols),
        .header_implicit  (header_implicit),
        .crc_on           (crc_on),
        .low_rate_opt     (low_rate_opt),
        .bandwidth_hz     (bandwidth_hz),
        .sym_valid        (sym_valid),
        .sym_req          (sym_req),
        .sym_sf           (sym_sf),
        .sym_bw           (sym_bw),
        .sym_q            (sym_q),
        .sym_side         (sym_side)
    );

    lto_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .sym_valid (sym_valid),
        .sym_req   (sym_req),
        .sym_sf    (sym_sf),
        .sym_bw    (sym_bw),
        .sym_q     (sym_q),
        .sym_side  (sym_side),
        .scl_valid (scl_valid),
        .scl_num   (scl_num),
        .scl_den   (scl_den),
        .scl_side  (scl_side)
    );

    // numerator < 2^60 and divisor >= 31200, so the top bits start below the divisor
    // and the quotient fits the result width
    assign dv[0]    = scl_valid;
    assign drem[0]  = lto_pkg::DEN_W'(scl_num[lto_pkg::NUM_W-1:lto_pkg::DUR_W]);
    assign dquo[0]  = scl_num[lto_pkg::DUR_W-1:0];
    assign dden[0]  = scl_den;
    assign dside[0] = scl_side;

    for (genvar g = 0; g < lto_pkg::DIV_STAGES; g++)
    begin : g_div
        lto_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv[g]),
            .in_rem    (drem[g]),
            .in_quo    (dquo[g]),
            .in_den    (dden[g]),
            .in_side   (dside[g]),
            .out_valid (dv[g+1]),
            .out_rem   (drem[g+1]),
            .out_quo   (dquo[g+1]),
            .out_den   (dden[g+1]),
            .out_side  (dside[g+1])
        );
    end

    assign rsp_valid                = dv[lto_pkg::DIV_STAGES];
    assign duration_ns              = dquo[lto_pkg::DIV_STAGES];
    assign payload_symbol_count     = dside[lto_pkg::DIV_STAGES].psym;
    assign preamble_quarter_symbols = dside[lto_pkg::DIV_STAGES].preq;

endmodule

// ===== design/lto_symbols.sv =====
// Settings decode, payload symbol count and quarter-symbol total (three stages).
module lto_symbols (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid,
    input  logic [1:0]                    req_type,
    input  logic [lto_pkg::LEN_W-1:0]     payload_len,
    input  logic [lto_pkg::SF_W-1:0]      spreading_factor,
    input  logic [lto_pkg::CR_W-1:0]      coding_rate,
    input  logic [lto_pkg::PRE_W-1:0]     preamble_symbols,
    input  logic                          header_implicit,
    input  logic                          crc_on,
    input  logic                          low_rate_opt,
    input  logic [lto_pkg::BW_W-1:0]      bandwidth_hz,
    output logic                          sym_valid,
    output lto_pkg::lto_req_t             sym_req,
    output logic [lto_pkg::SF_W-1:0]      sym_sf,
    output logic [lto_pkg::BW_W-1:0]      sym_bw,
    output logic [lto_pkg::Q_W-1:0]       sym_q,
    output lto_pkg::lto_side_t            sym_side
);

    // stage 1
    logic                          v1_reg;
    lto_pkg::lto_req_t             req1_reg, req1_next;
    logic [lto_pkg::SF_W-1:0]      sf1_reg, sf1_next;
    logic [lto_pkg::CR_W-1:0]      cr1_reg, cr1_next;
    logic [lto_pkg::BW_W-1:0]      bw1_reg, bw1_next;
    logic [lto_pkg::SF_W-1:0]      m1_reg, m1_next;
    logic [lto_pkg::Y_W-1:0]       y1_reg, y1_next;
    logic                          pos1_reg, pos1_next;
    logic [lto_pkg::PREQ_W-1:0]    preq1_reg, preq1_next;
    logic signed [lto_pkg::NUMS_W-1:0] num_s, x_s;

    // stage 2
    logic                          v2_reg;
    lto_pkg::lto_req_t             req2_reg;
    logic [lto_pkg::SF_W-1:0]      sf2_reg;
    logic [lto_pkg::CR_W-1:0]      cr2_reg;
    logic [lto_pkg::BW_W-1:0]      bw2_reg;
    logic [lto_pkg::PREQ_W-1:0]    preq2_reg;
    logic [lto_pkg::BLK_W-1:0]     blk2_reg, blk2_next;
    logic [lto_pkg::Y_W+lto_pkg::RECIP_W-1:0] blk_prod;

    // stage 3
    logic                          v3_reg;
    lto_pkg::lto_req_t             req3_reg;
    logic [lto_pkg::SF_W-1:0]      sf3_reg;
    logic [lto_pkg::BW_W-1:0]      bw3_reg;
    logic [lto_pkg::Q_W-1:0]       q3_reg, q3_next;
    lto_pkg::lto_side_t            side3_reg, side3_next;
    logic [lto_pkg::PSYM_W-1:0]    psym;
    logic [3:0]                    cr_plus4;

    always_comb
    begin
        req1_next = lto_pkg::lto_req_t'(req_type);
        if (spreading_factor < lto_pkg::SF_MIN)
            sf1_next = lto_pkg::SF_MIN;
        else if (spreading_factor > lto_pkg::SF_MAX)
            sf1_next = lto_pkg::SF_MAX;
        else
            sf1_next = spreading_factor;
        if (coding_rate < lto_pkg::CR_MIN)
            cr1_next = lto_pkg::CR_MIN;
        else if (coding_rate > lto_pkg::CR_MAX)
            cr1_next = lto_pkg::CR_MAX;
        else
            cr1_next = coding_rate;
        bw1_next = (bandwidth_hz < lto_pkg::BW_MIN) ? lto_pkg::BW_MIN : bandwidth_hz;

        // den = 4*m, m = sf - 2*de (4..12)
        m1_next = sf1_next - {2'b00, low_rate_opt, 1'b0};
        num_s = $signed({2'b00, payload_len, 3'b000}) + 13'sd28
              - $signed({7'b0000000, sf1_next, 2'b00})
              + (crc_on ? 13'sd16 : 13'sd0)
              - (header_implicit ? 13'sd20 : 13'sd0);
        x_s = num_s + $signed({7'b0000000, m1_next, 2'b00}) - 13'sd1;
        pos1_next = (num_s > 13'sd0);
        // ceil(num/4m) = floor(floor((num+4m-1)/4)/m)
        y1_next = x_s[lto_pkg::Y_W+1:2];

        if (req1_next == lto_pkg::REQ_TOA || req1_next == lto_pkg::REQ_PRE)
            preq1_next = {1'b0, preamble_symbols, 2'b00} + lto_pkg::PRE_EXTRA_Q;
        else
            preq1_next = '0;
    end

    always_comb
    begin
        blk_prod = {{lto_pkg::RECIP_W{1'b0}}, y1_reg}
                 * {{lto_pkg::Y_W{1'b0}}, lto_pkg::recip(m1_reg)};
        blk2_next = pos1_reg ? blk_prod[lto_pkg::RECIP_SHIFT +: lto_pkg::BLK_W] : '0;
    end

    always_comb
    begin
        cr_plus4 = {1'b0, cr2_reg} + 4'd4;
        psym = 11'd8 + ({3'b000, blk2_reg} * {7'b0000000, cr_plus4});
        unique case (req2_reg)
            lto_pkg::REQ_TOA: q3_next = preq2_reg + {6'b000000, psym, 2'b00};
            lto_pkg::REQ_RX1: q3_next = (sf2_reg >= lto_pkg::SF_LONG_RX) ?
                                        lto_pkg::RX1_Q_LONG : lto_pkg::RX1_Q_SHORT;
            lto_pkg::REQ_RX2: q3_next = '0;
            lto_pkg::REQ_PRE: q3_next = preq2_reg;
        endcase
        side3_next.psym = (req2_reg == lto_pkg::REQ_TOA) ? psym : '0;
        side3_next.preq = preq2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            req1_reg  <= req1_next;
            sf1_reg   <= sf1_next;
            cr1_reg   <= cr1_next;
            bw1_reg   <= bw1_next;
            m1_reg    <= m1_next;
            y1_reg    <= y1_next;
            pos1_reg  <= pos1_next;
            preq1_reg <= preq1_next;

            req2_reg  <= req1_reg;
            sf2_reg   <= sf1_reg;
            cr2_reg   <= cr1_reg;
            bw2_reg   <= bw1_reg;
            preq2_reg <= preq1_reg;
            blk2_reg  <= blk2_next;

            req3_reg  <= req2_reg;
            sf3_reg   <= sf2_reg;
            bw3_reg   <= bw2_reg;
            q3_reg    <= q3_next;
            side3_reg <= side3_next;
        end
    end

    assign sym_valid = v3_reg;
    assign sym_req   = req3_reg;
    assign sym_sf    = sf3_reg;
    assign sym_bw    = bw3_reg;
    assign sym_q     = q3_reg;
    assign sym_side  = side3_reg;

endmodule

// ===== design/lto_scale.sv =====
// Chip count and scaling to nanoseconds: numerator and divisor of the final division.
module lto_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          sym_valid,
    input  lto_pkg::lto_req_t             sym_req,
    input  logic [lto_pkg::SF_W-1:0]      sym_sf,
    input  logic [lto_pkg::BW_W-1:0]      sym_bw,
    input  logic [lto_pkg::Q_W-1:0]       sym_q,
    input  lto_pkg::lto_side_t            sym_side,
    output logic                          scl_valid,
    output logic [lto_pkg::NUM_W-1:0]     scl_num,
    output logic [lto_pkg::DEN_W-1:0]     scl_den,
    output lto_pkg::lto_side_t            scl_side
);

    logic                          v4_reg;
    logic [lto_pkg::K_W-1:0]       k4_reg, k4_next;
    logic [lto_pkg::BW_W-1:0]      bw4_reg;
    lto_pkg::lto_side_t            side4_reg;

    logic                          v5_reg;
    logic [lto_pkg::NUM_W-1:0]     num5_reg, num5_next;
    logic [lto_pkg::DEN_W-1:0]     den5_reg, den5_next;
    lto_pkg::lto_side_t            side5_reg;

    // window/CAD: 4*(2^sf + 32) quarter chips over 4*bw gives (2^sf+32)/bw
    always_comb
    begin
        if (sym_req == lto_pkg::REQ_RX2)
            k4_next = (lto_pkg::K_W'(4) << sym_sf) + lto_pkg::CAD_EXTRA_K;
        else
            k4_next = lto_pkg::K_W'(sym_q) << sym_sf;
    end

    always_comb
    begin
        num5_next = {{(lto_pkg::NUM_W-lto_pkg::K_W){1'b0}}, k4_reg}
                  * {{(lto_pkg::NUM_W-lto_pkg::NS_W){1'b0}}, lto_pkg::NS_PER_S};
        den5_next = {bw4_reg, 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= sym_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k4_reg    <= k4_next;
            bw4_reg   <= sym_bw;
            side4_reg <= sym_side;
            num5_reg  <= num5_next;
            den5_reg  <= den5_next;
            side5_reg <= side4_reg;
        end
    end

    assign scl_valid = v5_reg;
    assign scl_num   = num5_reg;
    assign scl_den   = den5_reg;
    assign scl_side  = side5_reg;

endmodule

// ===== design/lto_div_stage.sv =====
// One stage of the restoring divider: DIV_STEPS (two) quotient bits per stage.
module lto_div_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [lto_pkg::DEN_W-1:0]     in_rem,
    input  logic [lto_pkg::DUR_W-1:0]     in_quo,
    input  logic [lto_pkg::DEN_W-1:0]     in_den,
    input  lto_pkg::lto_side_t            in_side,
    output logic                          out_valid,
    output logic [lto_pkg::DEN_W-1:0]     out_rem,
    output logic [lto_pkg::DUR_W-1:0]     out_quo,
    output logic [lto_pkg::DEN_W-1:0]     out_den,
    output lto_pkg::lto_side_t            out_side
);

    logic                          v_reg;
    logic [lto_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [lto_pkg::DUR_W-1:0]     quo_reg, quo_next;
    logic [lto_pkg::DEN_W-1:0]     den_reg;
    lto_pkg::lto_side_t            side_reg;
    logic [lto_pkg::DEN_W:0]       trial;

    // quo holds the numerator bits still to come at the top, quotient bits at the bottom
    always_comb
    begin
        rem_next = in_rem;
        quo_next = in_quo;
        trial    = '0;
        for (int i = 0; i < lto_pkg::DIV_STEPS; i++)
        begin
            trial    = {rem_next, quo_next[lto_pkg::DUR_W-1]};
            quo_next = {quo_next[lto_pkg::DUR_W-2:0], 1'b0};
            if (trial >= {1'b0, in_den})
            begin
                rem_next    = lto_pkg::DEN_W'(trial - {1'b0, in_den});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[lto_pkg::DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = v_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule
